### rtl/tprc_pkg.sv
// Shared constants and types for the timer prescaler / reload calculator.
package tprc_pkg;

    // Default width of the input clock frequency that is used
    localparam int CLOCK_BITS_DEF = 32;

    // The reload register spans 2**RELOAD_SHIFT counts
    localparam int RELOAD_SHIFT = 16;

    // Reset value of the input clock register
    localparam logic [31:0] CLOCK_RESET = 32'd1;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### rtl/tprc_front.sv
// Front end: clock register, input handshake and rate classification.
module tprc_front #(
    parameter int CLOCK_BITS = tprc_pkg::CLOCK_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [31:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [31:0]               target_rate_hz,
    input  tprc_pkg::q_status_t       q_status,
    output logic                      push,
    output logic [2*CLOCK_BITS:0]     push_data
);

    logic [31:0]           clock_hz_reg;
    logic [CLOCK_BITS-1:0] clock_used;
    logic                  rejected;

    // Input clock register; the user must write it only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= tprc_pkg::CLOCK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            clock_hz_reg <= cfg_data;
        end
    end

    assign clock_used = clock_hz_reg[CLOCK_BITS-1:0];

    // Zero rate or rate above the clock is rejected
    assign rejected = (target_rate_hz == 32'd0) || (32'(clock_used) < target_rate_hz);

    // Take an item whenever the queue has room
    assign in_ready  = !q_status.full;
    assign push      = in_valid && in_ready;
    assign push_data = {!rejected, clock_used, target_rate_hz[CLOCK_BITS-1:0]};

endmodule

### rtl/tprc_queue.sv
// Short FIFO between the classifying front end and the divider back end.
module tprc_queue #(
    parameter int WIDTH = 2 * tprc_pkg::CLOCK_BITS_DEF + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     push_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     pop_data,
    output tprc_pkg::q_status_t  status
);

    localparam int PTR_W = tprc_pkg::QUEUE_PTR_W;

    logic [WIDTH-1:0] entry_reg [0:tprc_pkg::QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (PTR_W + 1)'(tprc_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

### rtl/tprc_back.sv
// Back end: two pipelined restoring dividers and the output register.
module tprc_back #(
    parameter int CLOCK_BITS = tprc_pkg::CLOCK_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tprc_pkg::q_status_t       q_status,
    input  logic [2*CLOCK_BITS:0]     pop_data,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      accepted,
    output logic [15:0]               prescaler,
    output logic [15:0]               reload,
    output logic [16:0]               period_ticks
);

    localparam int W = CLOCK_BITS;

    // One restoring step: shift in next dividend bit, trial subtract.
    // Returns {remainder, dividend/quotient shift word}.
    function automatic logic [2*W-1:0] div_step(
        input logic [W-1:0] rem,
        input logic [W-1:0] dq,
        input logic [W-1:0] dv
    );
        logic [W:0] trial;
        logic [W:0] diff;
        trial = {rem, dq[W-1]};
        diff  = trial - {1'b0, dv};
        if (!diff[W])
        begin
            return {diff[W-1:0], dq[W-2:0], 1'b1};
        end
        else
        begin
            return {trial[W-1:0], dq[W-2:0], 1'b0};
        end
    endfunction

    logic advance;

    // First divider: total = clock / rate
    logic         d1_v_reg   [1:W];
    logic         d1_ok_reg  [1:W];
    logic [W-1:0] d1_rem_reg [1:W];
    logic [W-1:0] d1_dq_reg  [1:W];
    logic [W-1:0] d1_dv_reg  [1:W];
    logic [2*W-1:0] d1_step  [1:W];

    // Middle stage: divisor for the second divider
    logic         mid_v_reg;
    logic         mid_ok_reg;
    logic [W-1:0] mid_total_reg;
    logic [W-1:0] mid_dv_reg;
    logic [W-1:0] total_dec;

    // Second divider: period = total / (prescaler + 1)
    logic         d2_v_reg   [1:W];
    logic         d2_ok_reg  [1:W];
    logic [W-1:0] d2_rem_reg [1:W];
    logic [W-1:0] d2_dq_reg  [1:W];
    logic [W-1:0] d2_dv_reg  [1:W];
    logic [2*W-1:0] d2_step  [1:W];

    // Output register
    logic         out_valid_reg;
    logic         accepted_reg;
    logic [15:0]  prescaler_reg;
    logic [15:0]  reload_reg;
    logic [16:0]  period_reg;
    logic [W-1:0] period_w;
    logic [W-1:0] presc_w;

    // Whole pipe moves unless a finished result is held
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && !q_status.empty;

    // Step logic of both dividers; queue entry is {ok, clock, rate}
    always_comb
    begin
        d1_step[1] = div_step('0, pop_data[2*W-1:W], pop_data[W-1:0]);
        d2_step[1] = div_step('0, mid_total_reg, mid_dv_reg);
        for (int k = 2; k <= W; k++)
        begin
            d1_step[k] = div_step(d1_rem_reg[k-1], d1_dq_reg[k-1], d1_dv_reg[k-1]);
            d2_step[k] = div_step(d2_rem_reg[k-1], d2_dq_reg[k-1], d2_dv_reg[k-1]);
        end
    end

    // prescaler + 1 = ((total - 1) >> RELOAD_SHIFT) + 1
    assign total_dec = d1_dq_reg[W] - W'(1);

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= W; k++)
            begin
                d1_v_reg[k] <= 1'b0;
                d2_v_reg[k] <= 1'b0;
            end
            mid_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            d1_v_reg[1] <= pop;
            d2_v_reg[1] <= mid_v_reg;
            for (int k = 2; k <= W; k++)
            begin
                d1_v_reg[k] <= d1_v_reg[k-1];
                d2_v_reg[k] <= d2_v_reg[k-1];
            end
            mid_v_reg     <= d1_v_reg[W];
            out_valid_reg <= d2_v_reg[W];
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d1_ok_reg[1]  <= pop_data[2*W];
            d1_dv_reg[1]  <= pop_data[W-1:0];
            d1_rem_reg[1] <= d1_step[1][2*W-1:W];
            d1_dq_reg[1]  <= d1_step[1][W-1:0];
            d2_ok_reg[1]  <= mid_ok_reg;
            d2_dv_reg[1]  <= mid_dv_reg;
            d2_rem_reg[1] <= d2_step[1][2*W-1:W];
            d2_dq_reg[1]  <= d2_step[1][W-1:0];
            for (int k = 2; k <= W; k++)
            begin
                d1_ok_reg[k]  <= d1_ok_reg[k-1];
                d1_dv_reg[k]  <= d1_dv_reg[k-1];
                d1_rem_reg[k] <= d1_step[k][2*W-1:W];
                d1_dq_reg[k]  <= d1_step[k][W-1:0];
                d2_ok_reg[k]  <= d2_ok_reg[k-1];
                d2_dv_reg[k]  <= d2_dv_reg[k-1];
                d2_rem_reg[k] <= d2_step[k][2*W-1:W];
                d2_dq_reg[k]  <= d2_step[k][W-1:0];
            end
            mid_ok_reg    <= d1_ok_reg[W];
            mid_total_reg <= d1_dq_reg[W];
            mid_dv_reg    <= (total_dec >> tprc_pkg::RELOAD_SHIFT) + W'(1);
        end
    end

    // Final fields; rejected items read as all zero
    assign period_w = d2_dq_reg[W];
    assign presc_w  = d2_dv_reg[W] - W'(1);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            accepted_reg <= d2_ok_reg[W];
            if (d2_ok_reg[W])
            begin
                prescaler_reg <= 16'(presc_w);
                reload_reg    <= 16'(period_w - W'(1));
                period_reg    <= 17'(period_w);
            end
            else
            begin
                prescaler_reg <= '0;
                reload_reg    <= '0;
                period_reg    <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign prescaler    = prescaler_reg;
    assign reload       = reload_reg;
    assign period_ticks = period_reg;

endmodule

### rtl/timer_prescaler_reload_calc_top.sv
// Top level of the timer prescaler / auto-reload calculator.
// Each item carries a requested rate; the block returns one result per item:
// prescaler = (clock/rate - 1) >> 16, period = (clock/rate) / (prescaler + 1),
// reload = period - 1, and accepted = 0 with all fields zero when the rate is
// zero or above the clock. One item is taken per cycle and one result leaves
// per cycle when the output is not stalled. Each item passes through the two
// pipelined bit-per-stage dividers, one stage between them and the output
// register; a four-entry queue sits ahead of the dividers, and the whole
// divider pipe holds while a result waits. The cfg channel writes the input
// clock register; the user must write it only while idle, it is not enforced.
module timer_prescaler_reload_calc_top #(
    parameter int CLOCK_BITS = tprc_pkg::CLOCK_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] target_rate_hz,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [15:0] prescaler,
    output logic [15:0] reload,
    output logic [16:0] period_ticks
);

    localparam int ENTRY_W = 2 * CLOCK_BITS + 1;

    tprc_pkg::q_status_t q_status;
    logic                push;
    logic                pop;
    logic [ENTRY_W-1:0]  push_data;
    logic [ENTRY_W-1:0]  pop_data;

    // Accept and classify
    tprc_front #(
        .CLOCK_BITS (CLOCK_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .target_rate_hz (target_rate_hz),
        .q_status       (q_status),
        .push           (push),
        .push_data      (push_data)
    );

    // Decoupling queue
    tprc_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // Divide and deliver
    tprc_back #(
        .CLOCK_BITS (CLOCK_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .prescaler    (prescaler),
        .reload       (reload),
        .period_ticks (period_ticks)
    );

endmodule

### verif/tprc_result_checker.sv
// Checker for the timer prescaler / reload calculator: predicts each result and compares it.
`timescale 1ns / 1ps

module tprc_result_checker #(
    parameter int CLOCK_BITS = tprc_pkg::CLOCK_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] target_rate_hz,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        accepted,
    input  logic [15:0] prescaler,
    input  logic [15:0] reload,
    input  logic [16:0] period_ticks,
    output int          fail_count,
    output int          pending,
    output int          requests_seen,
    output int          accepted_seen
);

    localparam logic [63:0] RELOAD_SPAN = 64'd1 << tprc_pkg::RELOAD_SHIFT;
    localparam logic [63:0] CLOCK_MASK  = (CLOCK_BITS >= 64) ? '1
                                          : ((64'd1 << CLOCK_BITS) - 64'd1);
    localparam logic [63:0] PRESC_MAX   = 64'hFFFF;
    localparam logic [63:0] PERIOD_MAX  = 64'h1_0000;

    typedef struct packed {
        logic        accepted;
        logic [15:0] prescaler;
        logic [15:0] reload;
        logic [16:0] period_ticks;
    } timer_setup_t;

    logic [31:0]  clock_hz;
    timer_setup_t setup_expect_q[$];

    // Prescaler / reload that the block should pick for one rate
    function automatic timer_setup_t calc_timer_setup(input logic [31:0] clk_reg,
                                                      input logic [31:0] rate);
        timer_setup_t res;
        logic [63:0]  clk_used;
        logic [63:0]  total;
        logic [63:0]  presc;
        logic [63:0]  period;
        logic [63:0]  reload_val;
        res      = '0;
        clk_used = {32'd0, clk_reg} & CLOCK_MASK;
        // zero rate or rate above the clock: rejected, all fields zero
        if (rate != 32'd0 && clk_used >= {32'd0, rate})
        begin
            total  = clk_used / {32'd0, rate};
            presc  = (total - 64'd1) / RELOAD_SPAN;
            period = total / (presc + 64'd1);
            // saturation only matters for non-default spans
            if (presc > PRESC_MAX)
                presc = PRESC_MAX;
            if (period > PERIOD_MAX)
                period = PERIOD_MAX;
            reload_val       = period - 64'd1;
            res.accepted     = 1'b1;
            res.prescaler    = presc[15:0];
            res.reload       = reload_val[15:0];
            res.period_ticks = period[16:0];
        end
        return res;
    endfunction

    task automatic report_field(input string name, input logic [16:0] exp_val,
                                input logic [16:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Watch all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch_blk
        timer_setup_t exp_res;
        if (!rst_n)
        begin
            clock_hz = tprc_pkg::CLOCK_RESET;
            setup_expect_q.delete();
            fail_count    = 0;
            pending       = 0;
            requests_seen = 0;
            accepted_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                clock_hz = cfg_data;
            if (in_valid && in_ready)
            begin
                setup_expect_q.push_back(calc_timer_setup(clock_hz, target_rate_hz));
                requests_seen++;
            end
            if (out_valid && out_ready)
            begin
                if (setup_expect_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected (acc %0b psc %0d arr %0d per %0d)",
                             $time, accepted, prescaler, reload, period_ticks);
                    fail_count++;
                end
                else
                begin
                    exp_res = setup_expect_q.pop_front();
                    report_field("accepted", {16'd0, exp_res.accepted}, {16'd0, accepted});
                    report_field("prescaler", {1'b0, exp_res.prescaler}, {1'b0, prescaler});
                    report_field("reload", {1'b0, exp_res.reload}, {1'b0, reload});
                    report_field("period_ticks", exp_res.period_ticks, period_ticks);
                    if (exp_res.accepted)
                        accepted_seen++;
                end
            end
            pending = setup_expect_q.size();
        end
    end

endmodule

### verif/tb_timer_prescaler_reload_calc_top.sv
// Testbench top for the timer prescaler / reload calculator: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_timer_prescaler_reload_calc_top;

    localparam int WATCHDOG_CYCLES  = 4000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int HOLD_AFTER       = 150;
    localparam int DRAIN_CYCLES     = 2 * tprc_pkg::CLOCK_BITS_DEF + 12;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] target_rate_hz;
    logic        out_valid;
    logic        out_ready;
    logic        accepted;
    logic [15:0] prescaler;
    logic [15:0] reload;
    logic [16:0] period_ticks;

    int fail_count;
    int pending;
    int requests_seen;
    int accepted_seen;

    logic [31:0] clock_now;
    int          sent_count;
    int          clock_writes;
    int          idle_cycles;

    timer_prescaler_reload_calc_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .target_rate_hz (target_rate_hz),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accepted       (accepted),
        .prescaler      (prescaler),
        .reload         (reload),
        .period_ticks   (period_ticks)
    );

    tprc_result_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .target_rate_hz (target_rate_hz),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accepted       (accepted),
        .prescaler      (prescaler),
        .reload         (reload),
        .period_ticks   (period_ticks),
        .fail_count     (fail_count),
        .pending        (pending),
        .requests_seen  (requests_seen),
        .accepted_seen  (accepted_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Rate shaped around the current clock so most requests land in range
    function automatic logic [31:0] pick_rate(input logic [31:0] clk_hz);
        int unsigned sel;
        logic [63:0] div;
        logic [63:0] r;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            r = 64'd0;
        else if (sel < 8)
            r = 64'hFFFF_FFFF;
        else if (sel < 14)
            r = {32'd0, clk_hz} + $urandom_range(0, 3);   // at or just above the clock
        else if (sel < 30)
            r = {32'd0, $urandom};
        else if (sel < 40)
            r = 64'd1 << $urandom_range(0, 31);
        else if (sel < 70)
        begin
            div = $urandom_range(1, 70000);
            r   = {32'd0, clk_hz} / div;
        end
        else
        begin
            // totals near a multiple of the reload span
            div = 64'd65536 * $urandom_range(1, 65535) + $urandom_range(0, 4) - 64'd2;
            r   = {32'd0, clk_hz} / div;
        end
        if (sel >= 40 && r == 64'd0)
            r = 64'd1;
        return r[31:0];
    endfunction

    // Every third block of 40 items goes back to back
    function automatic int unsigned pick_gap(input int n);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if ((n / 40) % 3 == 1 || sel < 55)
            return 0;
        else if (sel < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one rate; returns at a falling edge after the optional gap
    task automatic send_rate(input logic [31:0] rate);
        int unsigned gap;
        in_valid       <= 1'b1;
        target_rate_hz <= rate;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        gap = pick_gap(sent_count);
        sent_count++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_random(input int n);
        repeat (n) send_rate(pick_rate(clock_now));
    endtask

    task automatic wait_drained(input int extra);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // Clock register is only written with the pipe empty
    task automatic write_clock(input logic [31:0] hz);
        wait_drained(4);
        cfg_valid <= 1'b1;
        cfg_data  <= hz;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        clock_now = hz;
        clock_writes++;
    endtask

    // Result side: random stalls, plus one long hold-off to back up the input
    initial
    begin : result_side
        int unsigned sel;
        int unsigned run;
        bit          held;
        out_ready = 1'b0;
        held      = 1'b0;
        @(negedge clk);
        forever
        begin
            if (!held && requests_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                begin
                    out_ready <= 1'b1;
                    run = $urandom_range(1, 30);
                end
                else if (sel < 90)
                begin
                    out_ready <= 1'b0;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    out_ready <= 1'b0;
                    run = $urandom_range(8, 40);
                end
                repeat (run) @(negedge clk);
            end
        end
    end

    // Watchdog: too long without any item moving on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready)
            || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_CYCLES);
                $display("timer_prescaler_reload_calc_top: mismatch");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 32'd0;
        in_valid       = 1'b0;
        target_rate_hz = 32'd0;
        clock_now      = tprc_pkg::CLOCK_RESET;
        sent_count     = 0;
        clock_writes   = 0;
        idle_cycles    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset clock of 1 Hz: zero rate, rate equal to clock, rate above it
        send_rate(32'd0);
        send_rate(32'd1);
        send_rate(32'd2);
        send_random(40);

        // full-scale clock: largest prescaler, exact 65537 total, tiny totals
        write_clock(32'hFFFF_FFFF);
        send_rate(32'd0);
        send_rate(32'd1);
        send_rate(32'd2);
        send_rate(32'd65535);
        send_rate(32'd65536);
        send_rate(32'hFFFF_FFFE);
        send_rate(32'hFFFF_FFFF);
        send_random(120);

        // total of exactly one reload span, and two past it
        write_clock(32'h8000_0000);
        send_rate(32'd32768);
        send_rate(32'd32767);
        send_rate(32'h8000_0000);
        send_rate(32'h8000_0001);
        send_random(100);

        write_clock(32'd100_000_000);
        send_random(100);

        write_clock(($urandom == 32'd0) ? 32'd1 : $urandom);
        send_random(90);

        write_clock(32'd1);
        send_random(40);

        write_clock($urandom_range(1, 1 << 20));
        send_random(60);

        wait_drained(DRAIN_CYCLES);
        $display("Covered %0d rate requests (%0d in range) over %0d clock settings,",
                 requests_seen, accepted_seen, clock_writes + 1);
        $display("with random stalls, one long output hold-off and drains between settings.");
        if (fail_count == 0)
            $display("timer_prescaler_reload_calc_top: match");
        else
            $display("timer_prescaler_reload_calc_top: mismatch");
        $finish;
    end

endmodule

### files.f
rtl/tprc_pkg.sv
rtl/tprc_front.sv
rtl/tprc_queue.sv
rtl/tprc_back.sv
rtl/timer_prescaler_reload_calc_top.sv
verif/tprc_result_checker.sv
verif/tb_timer_prescaler_reload_calc_top.sv
